/* rtl/sorted_priority_queue_assert.svh */
// Assertion macros used by the priority queue module.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// Package with the types and codes of the sorted priority queue.
package spq_pkg;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int TAG_W    = 16;
    localparam int IKEY_W   = 32;
    localparam int POS_W    = 6;
    localparam int NUM_W    = 7;

    typedef enum logic [FUNC_W-1:0] {
        F_INSERT     = 3'd0,
        F_PEEK_FRONT = 3'd1,
        F_PEEK_BACK  = 3'd2,
        F_POP_FRONT  = 3'd3,
        F_POP_BACK   = 3'd4,
        F_READ_AT    = 3'd5,
        F_REMOVE_TAG = 3'd6,
        F_REMOVE_AT  = 3'd7
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_COMPACT,
        S_READ,
        S_DONE
    } t_state;

endpackage

/* rtl/sorted_priority_queue.sv */
// Sorted priority queue held in one synchronous memory with a sequencer.
// Peek and read pass through the read state to done; refused or empty requests go straight
// to done; insert scans entries, shifts later entries up and writes; pops and remove at read,
// then shift later entries down. Remove by tag walks every entry held, compacting the rest.
// One request at a time; the next is accepted the cycle after the result is taken.
// Reset (synchronous, active low) empties the queue; memory contents are not cleared.
module sorted_priority_queue #(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[2:0], sort_key[34:3], entry_tag[50:35], position[56:51], zero fill
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], out_tag[17:2], out_key[49:18], out_number[56:50],
    // queue_count[63:57]
    output logic [63:0] m_axis_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = KEY_WIDTH + spq_pkg::TAG_W;

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    spq_pkg::t_state  r_state, n_state;
    spq_pkg::t_func   r_func;
    logic [KEY_WIDTH-1:0] r_key;
    logic [spq_pkg::TAG_W-1:0] r_tag;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_wp, n_wp;
    logic [CW-1:0] r_num, n_num;
    logic          r_phase, n_phase;
    spq_pkg::t_status r_status, n_status;
    logic [spq_pkg::TAG_W-1:0] r_otag, n_otag;
    logic [KEY_WIDTH-1:0] r_okey, n_okey;
    logic          r_ovalid;

    logic [spq_pkg::FUNC_W-1:0] in_func;
    logic [spq_pkg::IKEY_W-1:0] in_key32;
    logic [KEY_WIDTH-1:0] in_key;
    logic [spq_pkg::POS_W-1:0]  in_pos;
    logic [CW-1:0] in_pos_c;
    logic in_pos_bad;
    logic accept;

    assign in_func  = s_axis_tdata[2:0];
    assign in_key32 = s_axis_tdata[34:3];
    assign in_pos   = s_axis_tdata[56:51];
    assign in_key   = KEY_WIDTH'($signed(in_key32));
    assign in_pos_c = CW'(in_pos);
    assign in_pos_bad = (32'(in_pos) >= 32'(r_count));
    assign s_axis_tready = (r_state == spq_pkg::S_IDLE) && !r_ovalid;
    assign accept = s_axis_tvalid && s_axis_tready;

    logic [KEY_WIDTH-1:0] rd_key;
    logic [spq_pkg::TAG_W-1:0] rd_tag;
    assign rd_key = r_rdata[EW-1:spq_pkg::TAG_W];
    assign rd_tag = r_rdata[spq_pkg::TAG_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (accept) begin
                    case (spq_pkg::t_func'(in_func))
                        spq_pkg::F_INSERT:
                            n_state = (r_count >= CW'(DEPTH)) ? spq_pkg::S_DONE
                                : spq_pkg::S_SCAN;
                        spq_pkg::F_REMOVE_TAG: n_state = spq_pkg::S_COMPACT;
                        spq_pkg::F_READ_AT, spq_pkg::F_REMOVE_AT:
                            n_state = in_pos_bad ? spq_pkg::S_DONE
                                : spq_pkg::S_READ;
                        default:
                            n_state = (r_count == '0) ? spq_pkg::S_DONE
                                : spq_pkg::S_READ;
                    endcase
                end
            end
            spq_pkg::S_SCAN: begin
                if (r_idx >= r_count) begin
                    n_state = spq_pkg::S_SHIFT_UP;
                end else if (r_phase && !($signed(rd_key) < $signed(r_key))) begin
                    n_state = spq_pkg::S_SHIFT_UP;
                end
            end
            spq_pkg::S_SHIFT_UP: begin
                if (r_wp == r_num) begin
                    n_state = spq_pkg::S_DONE;
                end
            end
            spq_pkg::S_READ: begin
                if (r_phase) begin
                    n_state = (r_func == spq_pkg::F_POP_FRONT || r_func == spq_pkg::F_POP_BACK
                        || r_func == spq_pkg::F_REMOVE_AT) ? spq_pkg::S_SHIFT_DOWN
                        : spq_pkg::S_DONE;
                end
            end
            spq_pkg::S_SHIFT_DOWN: begin
                if (r_idx + CW'(1) >= r_count) begin
                    n_state = spq_pkg::S_DONE;
                end
            end
            spq_pkg::S_COMPACT: begin
                if (r_idx >= r_count && !r_phase) begin
                    n_state = spq_pkg::S_DONE;
                end
            end
            spq_pkg::S_DONE: n_state = spq_pkg::S_IDLE;
            default: n_state = spq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_idx    = r_idx;
        n_wp     = r_wp;
        n_num    = r_num;
        n_phase  = 1'b0;
        n_status = r_status;
        n_otag   = r_otag;
        n_okey   = r_okey;
        mem_we    = 1'b0;
        mem_waddr = AW'(r_wp);
        mem_wdata = {r_key, r_tag};
        mem_raddr = AW'(r_idx);
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    n_wp = '0;
                    n_num = '0;
                    n_status = spq_pkg::ST_OK;
                    n_otag = '0;
                    n_okey = '0;
                    case (spq_pkg::t_func'(in_func))
                        spq_pkg::F_INSERT:
                            if (r_count >= CW'(DEPTH)) n_status = spq_pkg::ST_FULL;
                        spq_pkg::F_REMOVE_TAG: ;
                        spq_pkg::F_READ_AT, spq_pkg::F_REMOVE_AT: begin
                            if (in_pos_bad) n_status = spq_pkg::ST_EMPTY;
                            n_idx = in_pos_c;
                        end
                        spq_pkg::F_PEEK_BACK, spq_pkg::F_POP_BACK: begin
                            if (r_count == '0) n_status = spq_pkg::ST_EMPTY;
                            n_idx = r_count - CW'(1);
                        end
                        default:
                            if (r_count == '0) n_status = spq_pkg::ST_EMPTY;
                    endcase
                end
            end
            spq_pkg::S_SCAN: begin
                // Phase 0 issues the read, phase 1 compares the entry.
                if (r_idx < r_count) begin
                    if (!r_phase) begin
                        n_phase = 1'b1;
                    end else if ($signed(rd_key) < $signed(r_key)) begin
                        n_idx = r_idx + CW'(1);
                    end else begin
                        n_num = r_idx;
                        n_wp = r_count;
                    end
                end else begin
                    n_num = r_idx;
                    n_wp = r_count;
                end
                if (n_state == spq_pkg::S_SHIFT_UP) begin
                    mem_raddr = AW'(r_count - CW'(1));
                end
            end
            spq_pkg::S_SHIFT_UP: begin
                // Walk down from the end; phase 0 reads an entry, phase 1 writes it one slot up.
                if (r_wp == r_num) begin
                    mem_we = 1'b1;
                    mem_wdata = {r_key, r_tag};
                    n_count = r_count + CW'(1);
                end else if (!r_phase) begin
                    mem_raddr = AW'(r_wp - CW'(1));
                    n_phase = 1'b1;
                end else begin
                    mem_we = 1'b1;
                    mem_wdata = r_rdata;
                    n_wp = r_wp - CW'(1);
                end
            end
            spq_pkg::S_READ: begin
                if (r_phase) begin
                    n_otag = rd_tag;
                    n_okey = rd_key;
                    n_wp = r_idx;
                end else begin
                    n_phase = 1'b1;
                end
            end
            spq_pkg::S_SHIFT_DOWN: begin
                if (r_idx + CW'(1) >= r_count) begin
                    n_count = r_count - CW'(1);
                end else if (!r_phase) begin
                    mem_raddr = AW'(r_idx + CW'(1));
                    n_phase = 1'b1;
                end else begin
                    mem_we = 1'b1;
                    mem_waddr = AW'(r_idx);
                    mem_wdata = r_rdata;
                    n_idx = r_idx + CW'(1);
                end
            end
            spq_pkg::S_COMPACT: begin
                if (!r_phase) begin
                    if (r_idx < r_count) begin
                        n_phase = 1'b1;
                    end else begin
                        n_count = r_wp;
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                    if (rd_tag == r_tag) begin
                        n_num = r_num + CW'(1);
                    end else begin
                        mem_we = 1'b1;
                        mem_wdata = r_rdata;
                        n_wp = r_wp + CW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= spq_pkg::S_IDLE;
            r_count  <= '0;
            r_phase  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_phase <= n_phase;
            if (r_state == spq_pkg::S_DONE) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_wp     <= n_wp;
        r_num    <= n_num;
        r_status <= n_status;
        r_otag   <= n_otag;
        r_okey   <= n_okey;
        if (accept) begin
            r_func <= spq_pkg::t_func'(in_func);
            r_key  <= in_key;
            r_tag  <= s_axis_tdata[50:35];
        end
    end

    logic [spq_pkg::IKEY_W-1:0] okey32;
    assign okey32 = spq_pkg::IKEY_W'($signed(r_okey));

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {spq_pkg::NUM_W'(r_count), spq_pkg::NUM_W'(r_num), okey32, r_otag,
                            r_status};

    `include "sorted_priority_queue_assert.svh"

    `SPQ_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "count too big")
    `SPQ_ASSERT_IMP(a_busy_no_ready, i_clk, i_rst_n, r_state != spq_pkg::S_IDLE,
        !s_axis_tready, "ready while busy")
    `SPQ_ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == spq_pkg::S_DONE, m_axis_tvalid,
        "no result after done")

endmodule

/* tb/tb_sorted_priority_queue.sv */
// Self-checking testbench for the sorted priority queue: directed and random requests checked against a predictor.
module tb_sorted_priority_queue;

    localparam int DEPTH = 64;
    localparam int WDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;

    sorted_priority_queue #(.DEPTH(DEPTH), .KEY_WIDTH(32)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    logic [63:0] pending_requests[$];
    logic [63:0] expected_results[$];
    logic [31:0] model_keys[DEPTH];
    logic [15:0] model_tags[DEPTH];
    int          model_count;
    int          error_count;
    int          idle_cycles;
    int          gap_left;
    int          burst_left;
    int          stall_phase;
    int          requests_done;
    int          results_done;
    int          func_seen[8];
    bit          hold_sender;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] pack_request(spq_pkg::t_func f, logic [31:0] k,
                                                 logic [15:0] t, logic [5:0] p);
        return {7'd0, p, t, k, f};
    endfunction

    function automatic logic [63:0] queue_model_step(logic [63:0] req);
        spq_pkg::t_func   f;
        logic [31:0]      k;
        logic [15:0]      t;
        int               p;
        int               slot;
        spq_pkg::t_status st;
        logic [15:0]      otag;
        logic [31:0]      okey;
        int               onum;
        int               w;
        f = spq_pkg::t_func'(req[2:0]);
        k = req[34:3];
        t = req[50:35];
        p = int'(req[56:51]);
        st = spq_pkg::ST_OK;
        otag = '0;
        okey = '0;
        onum = 0;
        case (f)
            spq_pkg::F_INSERT: begin
                if (model_count >= DEPTH) begin
                    st = spq_pkg::ST_FULL;
                end else begin
                    slot = 0;
                    while (slot < model_count && $signed(model_keys[slot]) < $signed(k))
                        slot++;
                    for (int i = model_count; i > slot; i--) begin
                        model_keys[i] = model_keys[i-1];
                        model_tags[i] = model_tags[i-1];
                    end
                    model_keys[slot] = k;
                    model_tags[slot] = t;
                    model_count++;
                    onum = slot;
                end
            end
            spq_pkg::F_REMOVE_TAG: begin
                w = 0;
                for (int i = 0; i < model_count; i++) begin
                    if (model_tags[i] == t) begin
                        onum++;
                    end else begin
                        model_keys[w] = model_keys[i];
                        model_tags[w] = model_tags[i];
                        w++;
                    end
                end
                model_count = w;
            end
            default: begin
                if (f == spq_pkg::F_READ_AT || f == spq_pkg::F_REMOVE_AT) begin
                    slot = p;
                    if (p >= model_count) st = spq_pkg::ST_EMPTY;
                end else begin
                    slot = (f == spq_pkg::F_PEEK_FRONT || f == spq_pkg::F_POP_FRONT) ? 0
                        : model_count - 1;
                    if (model_count == 0) st = spq_pkg::ST_EMPTY;
                end
                if (st == spq_pkg::ST_OK) begin
                    otag = model_tags[slot];
                    okey = model_keys[slot];
                    if (f == spq_pkg::F_POP_FRONT || f == spq_pkg::F_POP_BACK
                        || f == spq_pkg::F_REMOVE_AT) begin
                        for (int i = slot; i + 1 < model_count; i++) begin
                            model_keys[i] = model_keys[i+1];
                            model_tags[i] = model_tags[i+1];
                        end
                        model_count--;
                    end
                end
            end
        endcase
        return {7'(model_count), 7'(onum), okey, otag, st};
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_left      <= 0;
            burst_left    <= 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
        end else if (hold_sender) begin
            s_axis_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= gap_left - 1;
        end else if (pending_requests.size() > 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pending_requests.pop_front();
            if (burst_left == 0) begin
                burst_left <= $urandom_range(20, 1);
                gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_phase   <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[9:8] == 2'd0)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(queue_model_step(s_axis_tdata));
                func_seen[s_axis_tdata[2:0]]++;
                requests_done++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_done++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, '0);
                end else begin
                    logic [63:0] want;
                    want = expected_results.pop_front();
                    if (m_axis_tdata[1:0] != want[1:0])
                        report_mismatch("status", m_axis_tdata, want);
                    if (m_axis_tdata[17:2] != want[17:2])
                        report_mismatch("out_tag", m_axis_tdata, want);
                    if (m_axis_tdata[49:18] != want[49:18])
                        report_mismatch("out_key", m_axis_tdata, want);
                    if (m_axis_tdata[56:50] != want[56:50])
                        report_mismatch("out_number", m_axis_tdata, want);
                    if (m_axis_tdata[63:57] != want[63:57])
                        report_mismatch("queue_count", m_axis_tdata, want);
                end
            end
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic add_random_requests(int n, int insert_bias);
        logic [31:0]    k;
        spq_pkg::t_func f;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: k = 32'h8000_0000 | $urandom_range(3);
                1: k = 32'h7fff_fffc | $urandom_range(3);
                2: k = $urandom_range(15) - 8;
                default: k = $urandom;
            endcase
            if ($urandom_range(99) < insert_bias) f = spq_pkg::F_INSERT;
            else f = spq_pkg::t_func'($urandom_range(7));
            pending_requests.push_back(pack_request(f, k,
                ($urandom_range(1) == 0) ? 16'($urandom_range(7)) : 16'($urandom),
                ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(7))));
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        model_count   = 0;
        error_count   = 0;
        idle_cycles   = 0;
        requests_done = 0;
        results_done  = 0;
        hold_sender   = 1'b0;
        foreach (func_seen[i]) func_seen[i] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty-queue corners, extreme keys, ties and bad positions.
        pending_requests.push_back(pack_request(spq_pkg::F_PEEK_FRONT, '0, '0, '0));
        pending_requests.push_back(pack_request(spq_pkg::F_PEEK_BACK, '0, '0, '0));
        pending_requests.push_back(pack_request(spq_pkg::F_POP_FRONT, '0, '0, '0));
        pending_requests.push_back(pack_request(spq_pkg::F_POP_BACK, '0, '0, '0));
        pending_requests.push_back(pack_request(spq_pkg::F_READ_AT, '0, '0, '0));
        pending_requests.push_back(pack_request(spq_pkg::F_REMOVE_AT, '0, '0, '0));
        pending_requests.push_back(pack_request(spq_pkg::F_REMOVE_TAG, '0, 16'hffff, '0));
        pending_requests.push_back(pack_request(spq_pkg::F_INSERT, 32'h7fff_ffff, 16'hffff,
                                                6'h3f));
        pending_requests.push_back(pack_request(spq_pkg::F_INSERT, 32'h8000_0000, 16'h0000,
                                                '0));
        pending_requests.push_back(pack_request(spq_pkg::F_INSERT, 32'd5, 16'h1111, '0));
        pending_requests.push_back(pack_request(spq_pkg::F_INSERT, 32'd5, 16'h2222, '0));
        pending_requests.push_back(pack_request(spq_pkg::F_INSERT, 32'hffff_ffff, 16'h1111,
                                                '0));
        pending_requests.push_back(pack_request(spq_pkg::F_PEEK_FRONT, '0, '0, '0));
        pending_requests.push_back(pack_request(spq_pkg::F_PEEK_BACK, '0, '0, '0));
        pending_requests.push_back(pack_request(spq_pkg::F_READ_AT, '0, '0, 6'd2));
        pending_requests.push_back(pack_request(spq_pkg::F_READ_AT, '0, '0, 6'h3f));
        pending_requests.push_back(pack_request(spq_pkg::F_REMOVE_AT, '0, '0, 6'd1));
        pending_requests.push_back(pack_request(spq_pkg::F_REMOVE_TAG, '0, 16'h1111, '0));
        pending_requests.push_back(pack_request(spq_pkg::F_POP_FRONT, '0, '0, '0));
        pending_requests.push_back(pack_request(spq_pkg::F_POP_BACK, '0, '0, '0));
        pending_requests.push_back(pack_request(spq_pkg::F_REMOVE_AT, '0, '0, 6'h3f));
        wait_drained();

        hold_sender = 1'b1;
        add_random_requests(250, 40);
        hold_sender = 1'b0;
        wait_drained();

        // Fill past capacity so inserts are refused, then work on a full queue.
        add_random_requests(120, 90);
        wait_drained();
        add_random_requests(380, 35);
        wait_drained();
        repeat (200) @(posedge i_clk);

        $display("covered %0d requests and %0d results; func mix %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 requests_done, results_done, func_seen[0], func_seen[1], func_seen[2],
                 func_seen[3], func_seen[4], func_seen[5], func_seen[6], func_seen[7]);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d results outstanding", error_count,
                     expected_results.size());
            $display("tb: failure");
        end
        $finish;
    end
endmodule
